>>> design/ipv6esp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6esp_pkg
// Shared types, constants and helpers for the IPv6 ESP SPI range matcher.
// ----------------------------------------------------------------------------
package ipv6esp_pkg;

    localparam int OFFSET_WIDTH_DEF = 16;
    localparam int SPI_W            = 32;
    localparam int CFG_INDEX_W      = 2;
    localparam int FIXED_HDR_LEN    = 40;
    localparam int NH_FIELD_OFFSET  = 6;
    localparam int FRAG_HDR_LEN     = 8;
    localparam int SPI_BYTES        = 4;
    localparam int DROP_MIN_BYTES   = 2;

    // next-header codes
    localparam logic [7:0] HDR_HOP      = 8'd0;
    localparam logic [7:0] HDR_ROUTING  = 8'd43;
    localparam logic [7:0] HDR_FRAGMENT = 8'd44;
    localparam logic [7:0] HDR_ESP      = 8'd50;
    localparam logic [7:0] HDR_AUTH     = 8'd51;
    localparam logic [7:0] HDR_DEST     = 8'd60;

    // config register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SPI_MIN      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPI_MAX      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_MATCH = 2'd2;

    typedef enum logic [2:0] {
        PH_FIXED = 3'd0,
        PH_WAIT  = 3'd1,
        PH_CHAIN = 3'd2,
        PH_ESP   = 3'd3,
        PH_FOUND = 3'd4,
        PH_FAIL  = 3'd5
    } phase_t;

    // walk outcome for the byte just taken, before the per-packet clear
    typedef struct packed {
        logic             found;
        logic             hot_drop;
        logic [SPI_W-1:0] spi;
    } walk_status_t;

    // phase when the walk is about to look at header type nh
    function automatic phase_t enter_header(input logic [7:0] nh);
        phase_t ph;
        ph = PH_FAIL;
        if (nh == HDR_ESP || nh == HDR_HOP || nh == HDR_ROUTING ||
            nh == HDR_FRAGMENT || nh == HDR_AUTH || nh == HDR_DEST)
        begin
            ph = PH_WAIT;
        end
        return ph;
    endfunction

endpackage
`default_nettype wire

>>> design/ipv6esp_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6esp_walk
// Per-byte walk of the IPv6 next-header chain and SPI capture.
// ----------------------------------------------------------------------------
module ipv6esp_walk #(
    parameter int OFFSET_WIDTH = ipv6esp_pkg::OFFSET_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      last_byte,
    output ipv6esp_pkg::walk_status_t      status
);

    localparam int LEN_W  = 12;
    localparam int NEXT_W = ((OFFSET_WIDTH > LEN_W) ? OFFSET_WIDTH : LEN_W) + 1;
    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

    logic [OFFSET_WIDTH-1:0]         offset_reg, offset_next;
    ipv6esp_pkg::phase_t             phase_reg, phase_next;
    logic [7:0]                      nh_reg, nh_next;
    logic [OFFSET_WIDTH-1:0]         hstart_reg, hstart_next;
    logic [7:0]                      chain_reg, chain_next;
    logic [ipv6esp_pkg::SPI_W-1:0]   spi_reg, spi_next;
    logic [2:0]                      count_reg, count_next;

    logic                            beyond;
    logic                            at_hstart;
    logic [NEXT_W-1:0]               hdr_len;
    logic [NEXT_W-1:0]               next_start;
    logic                            next_ovf;
    logic [2:0]                      count_inc;

    assign beyond    = (offset_reg == OFFSET_MAX) && (phase_reg != ipv6esp_pkg::PH_FIXED) &&
                       (offset_reg > hstart_reg);
    assign at_hstart = (offset_reg == hstart_reg);
    assign count_inc = count_reg + 3'd1;

    // header length from its second byte; fixed length for a fragment header
    always_comb
    begin
        if (nh_reg == ipv6esp_pkg::HDR_FRAGMENT)
        begin
            hdr_len = NEXT_W'(ipv6esp_pkg::FRAG_HDR_LEN);
        end
        else if (nh_reg == ipv6esp_pkg::HDR_AUTH)
        begin
            hdr_len = NEXT_W'({data_byte, 2'b00}) + NEXT_W'(8);
        end
        else
        begin
            hdr_len = NEXT_W'({data_byte, 3'b000}) + NEXT_W'(8);
        end
    end

    assign next_start = NEXT_W'(hstart_reg) + hdr_len;
    assign next_ovf   = (next_start[NEXT_W-1:OFFSET_WIDTH] != '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (beyond)
        begin
            if (phase_reg != ipv6esp_pkg::PH_FOUND)
            begin
                phase_next = ipv6esp_pkg::PH_FAIL;
            end
        end
        else
        begin
            unique case (phase_reg) inside
                ipv6esp_pkg::PH_FIXED:
                begin
                    if (offset_reg == OFFSET_WIDTH'(ipv6esp_pkg::FIXED_HDR_LEN - 1))
                    begin
                        phase_next = ipv6esp_pkg::enter_header(nh_reg);
                    end
                end
                ipv6esp_pkg::PH_WAIT:
                begin
                    if (at_hstart)
                    begin
                        phase_next = (nh_reg == ipv6esp_pkg::HDR_ESP) ?
                                     ipv6esp_pkg::PH_ESP : ipv6esp_pkg::PH_CHAIN;
                    end
                end
                ipv6esp_pkg::PH_CHAIN:
                begin
                    phase_next = next_ovf ? ipv6esp_pkg::PH_FAIL :
                                 ipv6esp_pkg::enter_header(chain_reg);
                end
                ipv6esp_pkg::PH_ESP:
                begin
                    if (count_inc >= 3'(ipv6esp_pkg::SPI_BYTES))
                    begin
                        phase_next = ipv6esp_pkg::PH_FOUND;
                    end
                end
                ipv6esp_pkg::PH_FOUND,
                ipv6esp_pkg::PH_FAIL:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    phase_next = ipv6esp_pkg::PH_FAIL;
                end
            endcase
        end
    end

    // datapath next values
    always_comb
    begin
        nh_next     = nh_reg;
        hstart_next = hstart_reg;
        chain_next  = chain_reg;
        spi_next    = spi_reg;
        count_next  = count_reg;
        offset_next = (offset_reg == OFFSET_MAX) ? offset_reg : offset_reg + 1'b1;
        if (!beyond)
        begin
            case (phase_reg)
                ipv6esp_pkg::PH_FIXED:
                begin
                    if (offset_reg == OFFSET_WIDTH'(ipv6esp_pkg::NH_FIELD_OFFSET))
                    begin
                        nh_next = data_byte;
                    end
                end
                ipv6esp_pkg::PH_WAIT:
                begin
                    if (at_hstart)
                    begin
                        if (nh_reg == ipv6esp_pkg::HDR_ESP)
                        begin
                            spi_next   = ipv6esp_pkg::SPI_W'(data_byte);
                            count_next = 3'd1;
                        end
                        else
                        begin
                            chain_next = data_byte;
                        end
                    end
                end
                ipv6esp_pkg::PH_CHAIN:
                begin
                    nh_next = chain_reg;
                    if (!next_ovf)
                    begin
                        hstart_next = next_start[OFFSET_WIDTH-1:0];
                    end
                end
                ipv6esp_pkg::PH_ESP:
                begin
                    spi_next   = {spi_reg[ipv6esp_pkg::SPI_W-9:0], data_byte};
                    count_next = count_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    // outcome as seen after this byte
    always_comb
    begin
        status.found    = (phase_next == ipv6esp_pkg::PH_FOUND);
        status.hot_drop = (phase_next == ipv6esp_pkg::PH_ESP) &&
                          (count_next >= 3'(ipv6esp_pkg::DROP_MIN_BYTES));
        status.spi      = spi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            phase_reg  <= ipv6esp_pkg::PH_FIXED;
            nh_reg     <= '0;
            hstart_reg <= OFFSET_WIDTH'(ipv6esp_pkg::FIXED_HDR_LEN);
            chain_reg  <= '0;
            spi_reg    <= '0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                offset_reg <= '0;
                phase_reg  <= ipv6esp_pkg::PH_FIXED;
                nh_reg     <= '0;
                hstart_reg <= OFFSET_WIDTH'(ipv6esp_pkg::FIXED_HDR_LEN);
                chain_reg  <= '0;
                spi_reg    <= '0;
                count_reg  <= '0;
            end
            else
            begin
                offset_reg <= offset_next;
                phase_reg  <= phase_next;
                nh_reg     <= nh_next;
                hstart_reg <= hstart_next;
                chain_reg  <= chain_next;
                spi_reg    <= spi_next;
                count_reg  <= count_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_found_full_spi: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ipv6esp_pkg::PH_FOUND |-> count_reg == 3'(ipv6esp_pkg::SPI_BYTES))
        else $error("found phase without a full SPI");

    a_esp_partial: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ipv6esp_pkg::PH_ESP |-> (count_reg != 3'd0) &&
        (count_reg < 3'(ipv6esp_pkg::SPI_BYTES)))
        else $error("ESP phase with bad byte count");

    a_hstart_floor: assert property (@(posedge clk) disable iff (!rst_n)
        hstart_reg >= OFFSET_WIDTH'(ipv6esp_pkg::FIXED_HDR_LEN))
        else $error("header start below end of fixed header");
`endif

endmodule
`default_nettype wire

>>> design/ipv6esp_spi_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6esp_spi_cmp
// SPI range test with optional inversion, gated by a found SPI.
// ----------------------------------------------------------------------------
module ipv6esp_spi_cmp (
    input  wire logic [ipv6esp_pkg::SPI_W-1:0] spi_min,
    input  wire logic [ipv6esp_pkg::SPI_W-1:0] spi_max,
    input  wire logic                          invert_match,
    input  wire ipv6esp_pkg::walk_status_t     status,
    output logic                               spi_matched,
    output logic                               hot_drop
);

    logic in_range;

    assign in_range    = (status.spi >= spi_min) && (status.spi <= spi_max);
    assign spi_matched = status.found && (in_range ^ invert_match);
    assign hot_drop    = status.hot_drop;

endmodule
`default_nettype wire

>>> design/ipv6_esp_spi_range_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_esp_spi_range_match
// Walks the IPv6 extension header chain one byte per cycle (a last byte may
// stall) and range-checks the ESP SPI; one result per packet on the last byte.
// ----------------------------------------------------------------------------
//
//  channel  | signals                       | moves
//  ---------+-------------------------------+---------------------------------
//  s_*      | tvalid tready tdata[7:0] tlast| packet byte; tlast = last byte
//  m_*      | tvalid tready tdata[7:0]      | per-packet match result
//  cfg_*    | we index[1:0] data[31:0]      | write spi_min / spi_max / invert
//
//  Throughput: one byte request per cycle unless a last byte stalls; the header
//  walk is combinational between the input register and the result register.
//  Result path: input register, then result register, which drives m_tvalid.
//  Stalls: only a last byte waits, while the result register is still full
//  and m_tready is low; other bytes move on regardless of m_tready.
//  Reset: asynchronous, clears walk state and loads register defaults
//  (spi_min 0, spi_max all ones, invert off); no clearing pass.
//
module ipv6_esp_spi_range_match #(
    parameter int OFFSET_WIDTH = ipv6esp_pkg::OFFSET_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  wire logic                                s_tlast,   // last_byte
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,   // [0] spi_matched,
                                                                // [1] hot_drop, rest 0
    // config writes
    input  wire logic                                cfg_we,
    input  wire logic [ipv6esp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ipv6esp_pkg::SPI_W-1:0]       cfg_data
);

    // config registers
    logic [ipv6esp_pkg::SPI_W-1:0] spi_min_reg;
    logic [ipv6esp_pkg::SPI_W-1:0] spi_max_reg;
    logic                          invert_reg;

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic       out_vld_reg, out_vld_next;
    logic       out_match_reg;
    logic       out_drop_reg;

    logic                      advance;
    logic                      load_result;
    ipv6esp_pkg::walk_status_t status;
    logic                      res_match;
    logic                      res_drop;

    // A byte leaves the input register unless it is the last one and the
    // result register cannot take its result this cycle.
    assign advance     = in_vld_reg && (!in_last_reg || !out_vld_reg || m_tready);
    assign load_result = advance && in_last_reg;
    assign s_tready    = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load_result)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (load_result)
        begin
            out_match_reg <= res_match;
            out_drop_reg  <= res_drop;
        end
    end

    // register writes; index beyond the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spi_min_reg <= '0;
            spi_max_reg <= '1;
            invert_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ipv6esp_pkg::REG_SPI_MIN:      spi_min_reg <= cfg_data;
                ipv6esp_pkg::REG_SPI_MAX:      spi_max_reg <= cfg_data;
                ipv6esp_pkg::REG_INVERT_MATCH: invert_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    ipv6esp_walk #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .status    (status)
    );

    ipv6esp_spi_cmp u_cmp (
        .spi_min      (spi_min_reg),
        .spi_max      (spi_max_reg),
        .invert_match (invert_reg),
        .status       (status),
        .spi_matched  (res_match),
        .hot_drop     (res_drop)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_drop_reg, out_match_reg};

`ifndef NO_ASSERTIONS
    a_match_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("match and hot drop both set");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_vld_reg && in_last_reg))
        else $error("result without a last byte");

    a_mid_bytes_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !in_last_reg) |-> s_tready)
        else $error("non-last byte stalled the input");
`endif

endmodule
`default_nettype wire
